[rtl/sample_histogram_jitter_monitor_defines.svh]
// ----------------------------------------------------------------------------
// Sample histogram jitter monitor assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_HISTOGRAM_JITTER_MONITOR_DEFINES_SVH
`define SAMPLE_HISTOGRAM_JITTER_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled while the given condition is high.
`define SHJM_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shjm assertion failed");

// Next-cycle implication, disabled while the given condition is high.
`define SHJM_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shjm assertion failed");

`endif

[rtl/shjm_pkg.sv]
// ----------------------------------------------------------------------------
// Sample histogram jitter monitor package
// Widths, command codes, queue entry and result types shared by the block.
// ----------------------------------------------------------------------------
package shjm_pkg;

   localparam int HIST_BINS        = 4096;
   localparam int BIN_AW           = $clog2(HIST_BINS);
   localparam int MAX_SAMPLE_LIMIT = 1024;

   localparam int CNT_W = 11;
   localparam int VAL_W = 12;
   localparam int TS_W  = 32;
   localparam int JIT_W = 36;

   localparam logic [CNT_W-1:0] LIMIT_RESET = 11'd1000;
   localparam logic [VAL_W-1:0] VALUE_MIN_RESET = 12'd4095;

   // One timer tick is 125/10 ns, applied as a multiply by 25 and a halving.
   localparam int TICK_NUM  = 125;
   localparam int TICK_DEN  = 10;
   localparam int JIT_MUL   = (TICK_NUM * 2) / TICK_DEN;
   localparam int JIT_SHIFT = 1;
   localparam int PROD_W    = TS_W + $clog2(JIT_MUL);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 160;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EXEC,
      ST_DIFF,
      ST_FINISH
   } state_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [VAL_W-1:0]  value;
      logic [TS_W-1:0]   timestamp;
      logic [BIN_AW-1:0] addr;
      logic              in_range;
   } queue_entry_type;

   typedef struct packed {
      logic              full;
      logic              empty;
   } queue_status_type;

   typedef struct packed {
      logic [CNT_W-1:0]  bin_count;
      logic              sample_accepted;
      logic [CNT_W-1:0]  samples_taken;
      logic              capture_done;
      logic [VAL_W-1:0]  min_sample;
      logic [VAL_W-1:0]  max_sample;
      logic [CNT_W-1:0]  peak_bin_count;
      logic [TS_W-1:0]   min_interval;
      logic [TS_W-1:0]   max_interval;
      logic [JIT_W-1:0]  jitter_ns;
   } rsp_fields_type;

endpackage

[rtl/sample_histogram_jitter_monitor.sv]
// ----------------------------------------------------------------------------
// Sample histogram jitter monitor
// Histogram, value range and timestamp interval tracking of converter samples.
// ----------------------------------------------------------------------------
// The req channel carries one command per transaction: tuser selects sample,
// read bin, clear or status, and tdata holds the sample value, its
// down-counting timestamp and the bin to read. Every command returns exactly
// one rsp transaction with the bin count and the full tracker status.
// The back end finishes one command before it starts the next, stepping
// through its read, update, interval difference and result steps on the
// histogram store. A two-entry queue lets req accept while a result waits
// on rsp. When the rsp receiver stalls, the result register holds and the
// back end waits, so req fills the queue and then drops req_tready. After
// reset, and after each clear command, all 4096 bins of the histogram store
// are zeroed while req_tready is low; the csr channel takes the sample limit
// at any time the block is idle and saturates it to 1024.
// ----------------------------------------------------------------------------
module sample_histogram_jitter_monitor
   import shjm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [11:0] sample_value, [43:12] timestamp, [55:44] bin_index
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] cmd
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [10:0] bin_count, [11] sample_accepted, [22:12] samples_taken,
   // [23] capture_done, [35:24] min_sample, [47:36] max_sample,
   // [58:48] peak_bin_count, [90:59] min_interval, [122:91] max_interval,
   // [158:123] jitter_ns, [159] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CNT_W-1:0]      csr_data
);

   queue_entry_type  push_entry;
   queue_entry_type  head;
   queue_status_type q_status;
   logic             push;
   logic             pop;
   logic             sweeping;
   rsp_fields_type   rsp_fields;

   shjm_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .sweeping   (sweeping),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   shjm_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   shjm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .sweeping   (sweeping),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_fields (rsp_fields)
   );

   assign rsp_tdata = {1'b0,
                       rsp_fields.jitter_ns,
                       rsp_fields.max_interval,
                       rsp_fields.min_interval,
                       rsp_fields.peak_bin_count,
                       rsp_fields.max_sample,
                       rsp_fields.min_sample,
                       rsp_fields.capture_done,
                       rsp_fields.samples_taken,
                       rsp_fields.sample_accepted,
                       rsp_fields.bin_count};

endmodule

[rtl/shjm_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module shjm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/shjm_fifo.sv]
// ----------------------------------------------------------------------------
// Sample histogram jitter monitor command queue
// Short queue of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module shjm_fifo
   import shjm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  queue_entry_type  push_entry,
   input  logic             pop,
   output queue_entry_type  head,
   output queue_status_type status
);

   queue_entry_type   entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

[rtl/shjm_front.sv]
// ----------------------------------------------------------------------------
// Sample histogram jitter monitor front end
// Accepts request transactions, decodes the command and bin address.
// ----------------------------------------------------------------------------
module shjm_front
   import shjm_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  sweeping,
   input  queue_status_type      q_status,
   output logic                  push,
   output queue_entry_type       push_entry
);

   logic [VAL_W-1:0] sample_value;
   logic [TS_W-1:0]  timestamp;
   logic [VAL_W-1:0] bin_index;
   logic [VAL_W-1:0] sel_index;
   cmd_type          cmd;

   assign sample_value = req_tdata[11:0];
   assign timestamp    = req_tdata[43:12];
   assign bin_index    = req_tdata[55:44];
   assign cmd          = cmd_type'(req_tuser);

   always_comb begin
      case (cmd)
         CMD_READ: sel_index = bin_index;
         default:  sel_index = sample_value;
      endcase
   end

   assign push_entry.cmd       = cmd;
   assign push_entry.value     = sample_value;
   assign push_entry.timestamp = timestamp;
   assign push_entry.addr      = BIN_AW'(sel_index);
   assign push_entry.in_range  = (32'(sel_index) < 32'(HIST_BINS));

   assign req_tready = !q_status.full && !sweeping;
   assign push       = req_tvalid && req_tready;

endmodule

[rtl/shjm_back.sv]
// ----------------------------------------------------------------------------
// Sample histogram jitter monitor back end
// Executes queued commands against the histogram store and the trackers.
// ----------------------------------------------------------------------------
module shjm_back
   import shjm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_entry_type  head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             sweeping,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CNT_W-1:0] csr_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_fields_type   rsp_fields
);

   state_type         state_ff, state_in;
   logic [BIN_AW-1:0] sweep_addr_ff, sweep_addr_in;
   queue_entry_type   cur_ff, cur_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TS_W-1:0]   last_ts_ff, last_ts_in;
   logic [TS_W-1:0]   imin_ff, imin_in;
   logic [TS_W-1:0]   imax_ff, imax_in;
   logic [VAL_W-1:0]  vmin_ff, vmin_in;
   logic [VAL_W-1:0]  vmax_ff, vmax_in;
   logic [CNT_W-1:0]  peak_ff, peak_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   logic              accepted_ff, accepted_in;
   logic [CNT_W-1:0]  bin_ff, bin_in;
   logic [TS_W-1:0]   diff_ff, diff_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_fields_type    rsp_ff, rsp_in;

   logic              start;
   logic              sweep_last;
   logic              take;
   logic [CNT_W-1:0]  bump;
   logic [TS_W-1:0]   interval;
   logic [PROD_W-1:0] jit_prod;

   logic              rd_en;
   logic [BIN_AW-1:0] rd_addr;
   logic [CNT_W-1:0]  rd_data;
   logic              wr_en;
   logic [BIN_AW-1:0] wr_addr;
   logic [CNT_W-1:0]  wr_data;

   shjm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (HIST_BINS)
   ) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign start      = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign sweep_last = (sweep_addr_ff == BIN_AW'(HIST_BINS - 1));
   assign take       = (count_ff < limit_ff);
   assign bump       = rd_data + CNT_W'(1);
   assign interval   = last_ts_ff - cur_ff.timestamp;
   assign jit_prod   = PROD_W'(diff_ff) * PROD_W'(JIT_MUL);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC:   state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_FINISH;
         ST_FINISH: state_in = (cur_ff.cmd == CMD_CLEAR) ? ST_SWEEP : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop     = 1'b0;
      rd_en   = 1'b0;
      rd_addr = head.addr;
      wr_en   = 1'b0;
      wr_addr = cur_ff.addr;
      wr_data = bump;
      case (state_ff)
         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = sweep_addr_ff;
            wr_data = '0;
         end
         ST_IDLE: begin
            pop   = start;
            rd_en = start;
         end
         ST_EXEC: begin
            wr_en = (cur_ff.cmd == CMD_SAMPLE) && take && cur_ff.in_range;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      sweep_addr_in = sweep_addr_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      last_ts_in    = last_ts_ff;
      imin_in       = imin_ff;
      imax_in       = imax_ff;
      vmin_in       = vmin_ff;
      vmax_in       = vmax_ff;
      peak_in       = peak_ff;
      limit_in      = limit_ff;
      accepted_in   = accepted_ff;
      bin_in        = bin_ff;
      diff_in       = diff_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      if (csr_valid) begin
         limit_in = (32'(csr_data) > 32'(MAX_SAMPLE_LIMIT)) ?
                    CNT_W'(MAX_SAMPLE_LIMIT) : csr_data;
      end

      case (state_ff)
         ST_SWEEP: begin
            sweep_addr_in = sweep_last ? '0 : sweep_addr_ff + BIN_AW'(1);
         end
         ST_IDLE: begin
            if (start) begin
               cur_in = head;
            end
         end
         ST_EXEC: begin
            accepted_in = 1'b0;
            bin_in      = '0;
            case (cur_ff.cmd)
               CMD_SAMPLE: begin
                  if (take) begin
                     accepted_in = 1'b1;
                     if (cur_ff.in_range && (bump > peak_ff)) begin
                        peak_in = bump;
                     end
                     if (cur_ff.value > vmax_ff) begin
                        vmax_in = cur_ff.value;
                     end
                     if (cur_ff.value < vmin_ff) begin
                        vmin_in = cur_ff.value;
                     end
                     if (count_ff != '0) begin
                        if (interval > imax_ff) begin
                           imax_in = interval;
                        end
                        if (interval < imin_ff) begin
                           imin_in = interval;
                        end
                     end
                     last_ts_in = cur_ff.timestamp;
                     count_in   = count_ff + CNT_W'(1);
                  end
               end
               CMD_READ: begin
                  bin_in = cur_ff.in_range ? rd_data : '0;
               end
               CMD_CLEAR: begin
                  count_in   = '0;
                  last_ts_in = '0;
                  imin_in    = '1;
                  imax_in    = '0;
                  vmin_in    = VALUE_MIN_RESET;
                  vmax_in    = '0;
                  peak_in    = '0;
               end
               default: begin
                  bin_in = '0;
               end
            endcase
         end
         ST_DIFF: begin
            diff_in = (count_ff >= CNT_W'(2)) ? (imax_ff - imin_ff) : '0;
         end
         ST_FINISH: begin
            sweep_addr_in          = '0;
            rsp_valid_in           = 1'b1;
            rsp_in.bin_count       = bin_ff;
            rsp_in.sample_accepted = accepted_ff;
            rsp_in.samples_taken   = count_ff;
            rsp_in.capture_done    = (count_ff >= limit_ff);
            rsp_in.min_sample      = vmin_ff;
            rsp_in.max_sample      = vmax_ff;
            rsp_in.peak_bin_count  = peak_ff;
            rsp_in.min_interval    = imin_ff;
            rsp_in.max_interval    = imax_ff;
            rsp_in.jitter_ns       = JIT_W'(jit_prod >> JIT_SHIFT);
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         count_ff      <= '0;
         last_ts_ff    <= '0;
         imin_ff       <= '1;
         imax_ff       <= '0;
         vmin_ff       <= VALUE_MIN_RESET;
         vmax_ff       <= '0;
         peak_ff       <= '0;
         limit_ff      <= LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         count_ff      <= count_in;
         last_ts_ff    <= last_ts_in;
         imin_ff       <= imin_in;
         imax_ff       <= imax_in;
         vmin_ff       <= vmin_in;
         vmax_ff       <= vmax_in;
         peak_ff       <= peak_in;
         limit_ff      <= limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      accepted_ff <= accepted_in;
      bin_ff      <= bin_in;
      diff_ff     <= diff_in;
      rsp_ff      <= rsp_in;
   end

   assign sweeping   = (state_ff == ST_SWEEP);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_fields = rsp_ff;

endmodule

[rtl/shjm_checker.sv]
// ----------------------------------------------------------------------------
// Sample histogram jitter monitor port checker
// Checks reset behavior, result holding and result consistency at the ports.
// ----------------------------------------------------------------------------
`include "sample_histogram_jitter_monitor_defines.svh"

module shjm_checker
   import shjm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic             accepted;
   logic [CNT_W-1:0] taken;
   logic [VAL_W-1:0] min_sample;
   logic [VAL_W-1:0] max_sample;
   logic [JIT_W-1:0] jitter;

   assign accepted   = rsp_tdata[11];
   assign taken      = rsp_tdata[22:12];
   assign min_sample = rsp_tdata[35:24];
   assign max_sample = rsp_tdata[47:36];
   assign jitter     = rsp_tdata[158:123];

   `SHJM_ASSERT_NXT(a_reset_quiet, clock, 1'b0, reset, !rsp_tvalid && !req_tready)
   `SHJM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `SHJM_ASSERT_IMP(a_jitter_early, clock, reset, rsp_tvalid && (taken < CNT_W'(2)), jitter == '0)
   `SHJM_ASSERT_IMP(a_sample_range, clock, reset, rsp_tvalid && accepted, (taken != '0) && (min_sample <= max_sample))

endmodule

bind sample_histogram_jitter_monitor shjm_checker u_shjm_checker (.*);

[tb/sv/tb_sample_histogram_jitter_monitor.sv]
// ----------------------------------------------------------------------------
// Sample histogram jitter monitor testbench
// Drives a table of directed commands and then random phases under several
// sample limits through the req and csr channels, expects each rsp from the
// table or an internal histogram and tracker model, and compares it field
// by field, with random idling, a long receiver stall and drain pauses.
// ----------------------------------------------------------------------------
module tb_sample_histogram_jitter_monitor
   import shjm_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 5;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 20;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_STALL     = 300;
   localparam int MAX_PRINTS     = 50;
   localparam int NS_PER_TICK_NUM = 125;
   localparam int NS_PER_TICK_DEN = 10;

   localparam logic [CNT_W-1:0] PHASE_LIMITS [6] = '{11'd300, 11'd1, 11'd2047, 11'd0,
                                                    11'd37, 11'd1024};
   localparam int               PHASE_ITEMS  [6] = '{90, 90, 90, 30, 90, 90};

   typedef struct packed {
      logic [CNT_W-1:0] bin_count;
      logic             sample_accepted;
      logic [CNT_W-1:0] samples_taken;
      logic             capture_done;
      logic [VAL_W-1:0] min_sample;
      logic [VAL_W-1:0] max_sample;
      logic [CNT_W-1:0] peak_bin_count;
      logic [TS_W-1:0]  min_interval;
      logic [TS_W-1:0]  max_interval;
      logic [JIT_W-1:0] jitter_ns;
   } monitor_result_type;

   typedef struct {
      bit                 is_csr;
      logic [CNT_W-1:0]   limit;
      cmd_type            cmd;
      logic [VAL_W-1:0]   value;
      logic [TS_W-1:0]    stamp;
      logic [VAL_W-1:0]   bin;
      bit                 typed;
      monitor_result_type want;
   } step_row_type;

   localparam monitor_result_type RESULT_RESET = '{
      bin_count: '0, sample_accepted: 1'b0, samples_taken: '0, capture_done: 1'b0,
      min_sample: 12'hFFF, max_sample: '0, peak_bin_count: '0,
      min_interval: 32'hFFFF_FFFF, max_interval: '0, jitter_ns: '0};

   localparam monitor_result_type RESULT_ZERO_LIMIT = '{
      bin_count: '0, sample_accepted: 1'b0, samples_taken: '0, capture_done: 1'b1,
      min_sample: 12'hFFF, max_sample: '0, peak_bin_count: '0,
      min_interval: 32'hFFFF_FFFF, max_interval: '0, jitter_ns: '0};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CNT_W-1:0]      csr_data = '0;

   // Model of the block's state.
   logic [CNT_W-1:0] hist_bins [HIST_BINS];
   logic [CNT_W-1:0] taken_count;
   logic [TS_W-1:0]  last_stamp;
   logic [TS_W-1:0]  gap_min;
   logic [TS_W-1:0]  gap_max;
   logic [VAL_W-1:0] value_lo;
   logic [VAL_W-1:0] value_hi;
   logic [CNT_W-1:0] peak_count;
   logic [CNT_W-1:0] limit_reg = LIMIT_RESET;

   monitor_result_type expected_results [$];
   int                 fault_count = 0;
   int                 idle_cycles = 0;
   int                 rsp_hold_cycles = 0;
   bit                 full_speed = 1'b0;

   step_row_type directed_steps [28] = '{
      // is_csr, limit, cmd, value, stamp, bin, typed, want
      '{1'b0, 11'd0,    CMD_NONE,   12'h000, 32'h0000_0000, 12'h000, 1'b1, RESULT_RESET},
      '{1'b0, 11'd0,    CMD_READ,   12'h000, 32'h0000_0000, 12'hFFF, 1'b1, RESULT_RESET},
      '{1'b1, 11'd6,    CMD_NONE,   12'h000, 32'h0000_0000, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'h000, 32'hFFFF_FFFF, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'hFFF, 32'h0000_0000, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'hFFF, 32'hFFFF_FFFF, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'h800, 32'hFFFF_FF00, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_READ,   12'h000, 32'h0000_0000, 12'hFFF, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_READ,   12'h000, 32'h0000_0000, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_READ,   12'h000, 32'h0000_0000, 12'h001, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'h555, 32'hAAAA_AAAA, 12'h555, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'hAAA, 32'h5555_5555, 12'hAAA, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'h001, 32'h5555_5500, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_NONE,   12'hFFF, 32'hFFFF_FFFF, 12'hFFF, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_CLEAR,  12'h000, 32'h0000_0000, 12'h000, 1'b1, RESULT_RESET},
      '{1'b0, 11'd0,    CMD_READ,   12'h000, 32'h0000_0000, 12'hFFF, 1'b1, RESULT_RESET},
      '{1'b1, 11'd0,    CMD_NONE,   12'h000, 32'h0000_0000, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'h007, 32'h0000_0005, 12'h000, 1'b1,
        RESULT_ZERO_LIMIT},
      '{1'b1, 11'd2047, CMD_NONE,   12'h000, 32'h0000_0000, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'hFFF, 32'h0000_0000, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'h000, 32'h0000_0000, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'hFFF, 32'hFFFF_FFFF, 12'h000, 1'b0, '0},
      '{1'b1, 11'd1,    CMD_NONE,   12'h000, 32'h0000_0000, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'h010, 32'hFFFF_FFF0, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_CLEAR,  12'h000, 32'h0000_0000, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'h123, 32'h8000_0000, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_SAMPLE, 12'h124, 32'h7FFF_FFFF, 12'h000, 1'b0, '0},
      '{1'b0, 11'd0,    CMD_READ,   12'h000, 32'h0000_0000, 12'h123, 1'b0, '0}
   };

   sample_histogram_jitter_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
            || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_sample_histogram_jitter_monitor: FAIL");
         $finish;
      end
   end

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_PRINTS) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
   endtask

   function automatic void clear_trackers();
      foreach (hist_bins[i]) begin
         hist_bins[i] = '0;
      end
      taken_count = '0;
      last_stamp  = '0;
      gap_min     = '1;
      gap_max     = '0;
      value_lo    = VALUE_MIN_RESET;
      value_hi    = '0;
      peak_count  = '0;
   endfunction

   function automatic logic [CNT_W-1:0] capture_limit();
      return (limit_reg > CNT_W'(MAX_SAMPLE_LIMIT)) ? CNT_W'(MAX_SAMPLE_LIMIT) : limit_reg;
   endfunction

   function automatic monitor_result_type predict_command(input cmd_type cmd,
         input logic [VAL_W-1:0] value, input logic [TS_W-1:0] stamp,
         input logic [VAL_W-1:0] bin);
      monitor_result_type r;
      logic [TS_W-1:0]    gap_ticks;
      longint unsigned    span;
      r = '0;
      case (cmd)
         CMD_SAMPLE: begin
            if (taken_count < capture_limit()) begin
               hist_bins[value] = hist_bins[value] + CNT_W'(1);
               if (hist_bins[value] > peak_count) begin
                  peak_count = hist_bins[value];
               end
               if (value > value_hi) begin
                  value_hi = value;
               end
               if (value < value_lo) begin
                  value_lo = value;
               end
               if (taken_count > 0) begin
                  gap_ticks = last_stamp - stamp;
                  if (gap_ticks > gap_max) begin
                     gap_max = gap_ticks;
                  end
                  if (gap_ticks < gap_min) begin
                     gap_min = gap_ticks;
                  end
               end
               last_stamp  = stamp;
               taken_count = taken_count + CNT_W'(1);
               r.sample_accepted = 1'b1;
            end
         end
         CMD_READ: begin
            r.bin_count = hist_bins[bin];
         end
         CMD_CLEAR: begin
            clear_trackers();
         end
         default: begin
         end
      endcase
      r.samples_taken  = taken_count;
      r.capture_done   = (taken_count >= capture_limit());
      r.min_sample     = value_lo;
      r.max_sample     = value_hi;
      r.peak_bin_count = peak_count;
      r.min_interval   = gap_min;
      r.max_interval   = gap_max;
      if (taken_count >= 2 && gap_max >= gap_min) begin
         span = longint'(gap_max) - longint'(gap_min);
         r.jitter_ns = JIT_W'((span * NS_PER_TICK_NUM) / NS_PER_TICK_DEN);
      end
      return r;
   endfunction

   task automatic send_command(input cmd_type cmd, input logic [VAL_W-1:0] value,
         input logic [TS_W-1:0] stamp, input logic [VAL_W-1:0] bin, input bit typed,
         input monitor_result_type typed_want, output monitor_result_type predicted);
      int gap;
      gap = full_speed ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {bin, stamp, value};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = predict_command(cmd, value, stamp, bin);
      expected_results.push_back(typed ? typed_want : predicted);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CNT_W-1:0] limit);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= limit;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      limit_reg = limit;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
         input logic [63:0] want);
      if (got !== want) begin
         report_fault($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   task automatic check_result(input logic [RSP_DATA_W-1:0] data);
      monitor_result_type got;
      monitor_result_type want;
      got.bin_count       = data[10:0];
      got.sample_accepted = data[11];
      got.samples_taken   = data[22:12];
      got.capture_done    = data[23];
      got.min_sample      = data[35:24];
      got.max_sample      = data[47:36];
      got.peak_bin_count  = data[58:48];
      got.min_interval    = data[90:59];
      got.max_interval    = data[122:91];
      got.jitter_ns       = data[158:123];
      if (expected_results.size() == 0) begin
         report_fault("rsp transaction with no command outstanding");
      end else begin
         want = expected_results.pop_front();
         check_field("bin_count", 64'(got.bin_count), 64'(want.bin_count));
         check_field("sample_accepted", 64'(got.sample_accepted),
                     64'(want.sample_accepted));
         check_field("samples_taken", 64'(got.samples_taken), 64'(want.samples_taken));
         check_field("capture_done", 64'(got.capture_done), 64'(want.capture_done));
         check_field("min_sample", 64'(got.min_sample), 64'(want.min_sample));
         check_field("max_sample", 64'(got.max_sample), 64'(want.max_sample));
         check_field("peak_bin_count", 64'(got.peak_bin_count), 64'(want.peak_bin_count));
         check_field("min_interval", 64'(got.min_interval), 64'(want.min_interval));
         check_field("max_interval", 64'(got.max_interval), 64'(want.max_interval));
         check_field("jitter_ns", 64'(got.jitter_ns), 64'(want.jitter_ns));
      end
   endtask

   // The receiver runs on its own and takes a long stall when one is requested.
   initial begin : receiver
      int gap;
      forever begin
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         gap = full_speed ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         check_result(rsp_tdata);
      end
   end

   initial begin : stimulus
      monitor_result_type result;
      cmd_type            cmd;
      logic [VAL_W-1:0]   value;
      logic [VAL_W-1:0]   last_value;
      logic [TS_W-1:0]    stamp;
      logic [TS_W-1:0]    stamp_now;
      logic [VAL_W-1:0]   bin;
      int                 pick;
      int                 clear_pct;
      int                 n;

      clear_trackers();
      last_value = '0;
      stamp_now  = $urandom;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_csr) begin
            write_limit(directed_steps[i].limit);
         end else begin
            send_command(directed_steps[i].cmd, directed_steps[i].value,
                         directed_steps[i].stamp, directed_steps[i].bin,
                         directed_steps[i].typed, directed_steps[i].want, result);
         end
      end

      for (int p = 0; p < $size(PHASE_LIMITS); p++) begin
         write_limit(PHASE_LIMITS[p]);
         if (p == 1) begin
            rsp_hold_cycles = LONG_STALL;
         end
         full_speed = (p == 1 || p == 2);
         n = 0;
         while (n < PHASE_ITEMS[p]) begin
            if (n == 40) begin
               full_speed = 1'b0;
               if (p == 0) begin
                  wait_drained();
               end
            end
            clear_pct = (taken_count >= capture_limit()) ? 15 : 1;
            pick = $urandom_range(0, 99);
            if (pick < clear_pct) begin
               cmd = CMD_CLEAR;
            end else if (pick >= 96) begin
               cmd = CMD_NONE;
            end else if (pick >= 74) begin
               cmd = CMD_READ;
            end else begin
               cmd = CMD_SAMPLE;
            end

            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               value = VAL_W'($urandom_range(2040, 2056));
            end else if (pick < 8) begin
               value = VAL_W'($urandom);
            end else begin
               value = (pick == 8) ? '0 : '1;
            end
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
               stamp = $urandom;
            end else if (pick == 1) begin
               stamp = stamp_now;
            end else begin
               stamp = stamp_now - TS_W'(73 + $urandom_range(0, 14));
            end
            pick = $urandom_range(0, 3);
            if (pick < 2) begin
               bin = VAL_W'($urandom_range(2040, 2056));
            end else if (pick == 2) begin
               bin = last_value;
            end else begin
               bin = VAL_W'($urandom);
            end

            send_command(cmd, value, stamp, bin, 1'b0, '0, result);
            if (cmd == CMD_SAMPLE) begin
               stamp_now  = stamp;
               last_value = value;
            end
            n++;
         end
      end

      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("tb_sample_histogram_jitter_monitor: PASS");
      end else begin
         $display("tb_sample_histogram_jitter_monitor: FAIL");
      end
      $finish;
   end

endmodule

[sample_histogram_jitter_monitor.f]
+incdir+rtl
rtl/shjm_pkg.sv
rtl/shjm_ram.sv
rtl/shjm_fifo.sv
rtl/shjm_front.sv
rtl/shjm_back.sv
rtl/sample_histogram_jitter_monitor.sv
rtl/shjm_checker.sv
tb/sv/tb_sample_histogram_jitter_monitor.sv
